/* hdl/elp_pkg.sv */
// Shared types, constants and width helpers for the edge list text parser.
package elp_pkg;

   localparam int BYTE_W              = 8;
   localparam int KEY_OUT_W           = 40;
   localparam int CSR_INDEX_W         = 1;
   localparam int MAX_KEY_DIGITS_DFLT = 12;
   localparam int DIGIT_W             = 4;

   localparam logic [BYTE_W-1:0]      CHAR_ZERO        = 8'h30;
   localparam logic [DIGIT_W-1:0]     DIGIT_MAX        = 4'd9;
   localparam logic [BYTE_W-1:0]      DELIM_ONE_RESET  = 8'd32;
   localparam logic [BYTE_W-1:0]      DELIM_TWO_RESET  = 8'd10;
   localparam logic [CSR_INDEX_W-1:0] REG_DELIM_ONE    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DELIM_TWO    = 1'd1;

   typedef enum logic [1:0] {
      ST_EDGE      = 2'd0,
      ST_TOO_LONG  = 2'd1,
      ST_MALFORMED = 2'd2
   } status_type;

   typedef struct packed {
      logic in_number;
      logic have_source;
      logic skipping_bad;
   } flags_type;

   typedef struct packed {
      logic       valid;
      status_type status;
   } result_type;

   // Bits needed to hold any key of the given number of decimal digits, never below
   // the output key width.
   function automatic int key_width(input int digits);
      int bits;
      bits = (digits * 3322 + 999) / 1000;
      return (bits > KEY_OUT_W) ? bits : KEY_OUT_W;
   endfunction

endpackage

/* hdl/elp_step.sv */
// Next-state and result logic for one text byte of the edge list parser.
module elp_step #(
   parameter int MAX_KEY_DIGITS = elp_pkg::MAX_KEY_DIGITS_DFLT,
   localparam int KEY_W = elp_pkg::key_width(MAX_KEY_DIGITS),
   localparam int CNT_W = $clog2(MAX_KEY_DIGITS + 1)
) (
   input  logic [elp_pkg::BYTE_W-1:0]    data_byte,
   input  logic                          chunk_end,
   input  logic [elp_pkg::BYTE_W-1:0]    delimiter_one,
   input  logic [elp_pkg::BYTE_W-1:0]    delimiter_two,
   input  logic [KEY_W-1:0]              acc,
   input  logic [CNT_W-1:0]              digit_count,
   input  elp_pkg::flags_type            flags,
   input  logic [KEY_W-1:0]              held_source,
   output logic [KEY_W-1:0]              acc_next,
   output logic [CNT_W-1:0]              digit_count_next,
   output elp_pkg::flags_type            flags_next,
   output logic [KEY_W-1:0]              held_source_next,
   output elp_pkg::result_type           result,
   output logic [elp_pkg::KEY_OUT_W-1:0] source_key,
   output logic [elp_pkg::KEY_OUT_W-1:0] dest_key
);
   import elp_pkg::*;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEY_DIGITS);

   logic               is_delim;
   logic               is_decimal;
   logic [DIGIT_W-1:0] digit;

   assign is_delim   = (data_byte == delimiter_one) || (data_byte == delimiter_two);
   assign digit      = DIGIT_W'(data_byte - CHAR_ZERO);
   assign is_decimal = (data_byte >= CHAR_ZERO) && (data_byte <= (CHAR_ZERO + BYTE_W'(DIGIT_MAX)));

   always_comb begin
      logic [KEY_W-1:0] key;
      logic             finish;
      acc_next         = acc;
      digit_count_next = digit_count;
      flags_next       = flags;
      held_source_next = held_source;
      result.valid     = 1'b0;
      result.status    = ST_EDGE;
      source_key       = '0;
      dest_key         = '0;
      finish           = 1'b0;
      key              = '0;

      if (is_delim) begin
         flags_next.skipping_bad = 1'b0;
         finish = flags.in_number;
      end else if (is_decimal) begin
         if (!flags.skipping_bad) begin
            if (digit_count >= MAX_CNT) begin
               acc_next                = '0;
               digit_count_next        = '0;
               flags_next.in_number    = 1'b0;
               flags_next.have_source  = 1'b0;
               held_source_next        = '0;
               flags_next.skipping_bad = 1'b1;
               result.valid            = 1'b1;
               result.status           = ST_TOO_LONG;
            end else begin
               acc_next             = (acc << 3) + (acc << 1) + KEY_W'(digit);
               digit_count_next     = digit_count + CNT_W'(1);
               flags_next.in_number = 1'b1;
            end
         end
      end else begin
         acc_next                = '0;
         digit_count_next        = '0;
         flags_next.in_number    = 1'b0;
         flags_next.skipping_bad = 1'b0;
         result.valid            = 1'b1;
         result.status           = ST_MALFORMED;
      end

      // A key that runs into the chunk end completes here; only one key can complete per byte.
      if (chunk_end && flags_next.in_number && !result.valid) begin
         finish = 1'b1;
      end

      if (finish) begin
         key                  = acc_next;
         acc_next             = '0;
         digit_count_next     = '0;
         flags_next.in_number = 1'b0;
         if (!flags_next.have_source) begin
            held_source_next       = key;
            flags_next.have_source = 1'b1;
         end else begin
            flags_next.have_source = 1'b0;
            if (held_source_next != key) begin
               result.valid  = 1'b1;
               result.status = ST_EDGE;
               source_key    = held_source_next[KEY_OUT_W-1:0];
               dest_key      = key[KEY_OUT_W-1:0];
            end
            held_source_next = '0;
         end
      end

      if (chunk_end) begin
         flags_next.skipping_bad = 1'b0;
         if (flags_next.have_source) begin
            flags_next.have_source = 1'b0;
            held_source_next       = '0;
            if (!result.valid) begin
               result.valid  = 1'b1;
               result.status = ST_MALFORMED;
            end
         end
      end
   end

endmodule

/* hdl/edge_list_text_parser_unit.sv */
// Top level of the edge list text parser: input register, parser state and result register.
//
// The unit reads decimal edge list text one byte per transfer, skips the two configured
// delimiter characters, gathers digit runs of up to MAX_KEY_DIGITS digits into vertex keys
// and pairs them into edges. An edge is reported with status 0 unless its two keys are
// equal, in which case it is dropped without a result. An over-long key reports status 1
// and drops the pending edge; a stray byte, or a chunk (marked by req_tlast) that ends
// with half an edge, reports status 2. Error results carry zero keys. One byte is taken
// per clock cycle while the result register is not stalled by rsp_tready; each byte is
// held in the input register and its result, if any, is then written to the result
// register. The rate is set by the multiply-by-ten accumulate and the key compare, which
// are combinational. Delimiters are written through the csr_ port; the user must write
// them only while no text is in flight, as the unit itself does not enforce this.
module edge_list_text_parser_unit #(
   parameter int MAX_KEY_DIGITS = elp_pkg::MAX_KEY_DIGITS_DFLT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // data_byte
   input  logic                            req_tlast,   // chunk_end
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [79:0]                     rsp_tdata,   // dest_key, source_key
   output logic [1:0]                      rsp_tuser,   // status
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [elp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                      csr_data
);
   import elp_pkg::*;

   localparam int KEY_W = key_width(MAX_KEY_DIGITS);
   localparam int CNT_W = $clog2(MAX_KEY_DIGITS + 1);

   logic                  in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]     in_byte_ff;
   logic                  in_last_ff;
   logic [BYTE_W-1:0]     delim_one_ff, delim_two_ff;
   logic [KEY_W-1:0]      acc_ff, acc_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   flags_type             flags_ff, flags_in;
   logic [KEY_W-1:0]      held_ff, held_in;
   logic                  out_valid_ff, out_valid_in;
   status_type            out_status_ff;
   logic [KEY_OUT_W-1:0]  out_src_ff, out_dst_ff;
   result_type            result;
   logic [KEY_OUT_W-1:0]  step_src, step_dst;
   logic                  advance;
   logic                  accept;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign accept       = req_tvalid && req_tready;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = (advance && result.valid) || (out_valid_ff && !rsp_tready);

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_dst_ff, out_src_ff};
   assign rsp_tuser  = out_status_ff;

   elp_step #(
      .MAX_KEY_DIGITS (MAX_KEY_DIGITS)
   ) u_step (
      .data_byte        (in_byte_ff),
      .chunk_end        (in_last_ff),
      .delimiter_one    (delim_one_ff),
      .delimiter_two    (delim_two_ff),
      .acc              (acc_ff),
      .digit_count      (count_ff),
      .flags            (flags_ff),
      .held_source      (held_ff),
      .acc_next         (acc_in),
      .digit_count_next (count_in),
      .flags_next       (flags_in),
      .held_source_next (held_in),
      .result           (result),
      .source_key       (step_src),
      .dest_key         (step_dst)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         delim_one_ff <= DELIM_ONE_RESET;
         delim_two_ff <= DELIM_TWO_RESET;
         acc_ff       <= '0;
         count_ff     <= '0;
         flags_ff     <= '0;
         held_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_DELIM_ONE) begin
               delim_one_ff <= csr_data;
            end else if (csr_index == REG_DELIM_TWO) begin
               delim_two_ff <= csr_data;
            end
         end
         if (advance) begin
            acc_ff   <= acc_in;
            count_ff <= count_in;
            flags_ff <= flags_in;
            held_ff  <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && result.valid) begin
         out_status_ff <= result.status;
         out_src_ff    <= step_src;
         out_dst_ff    <= step_dst;
      end
   end

endmodule

/* test/elp_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for the edge list text parser: predicts edges and errors and compares them.
module elp_result_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [7:0]                      req_tdata,
   input  logic                            req_tlast,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [79:0]                     rsp_tdata,
   input  logic [1:0]                      rsp_tuser,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [elp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                      csr_data,
   output int                              fail_count,
   output int                              pending
);
   import elp_pkg::*;

   localparam int KEY_DIGIT_LIMIT = MAX_KEY_DIGITS_DFLT;

   typedef struct packed {
      status_type           status;
      logic [KEY_OUT_W-1:0] source_key;
      logic [KEY_OUT_W-1:0] dest_key;
   } parsed_edge_type;

   parsed_edge_type   expected_edges[$];
   logic [BYTE_W-1:0] delim_a;
   logic [BYTE_W-1:0] delim_b;
   logic [63:0]       key_value;
   int                key_digits;
   bit                in_key;
   bit                have_src;
   logic [63:0]       src_value;
   bit                skipping;
   int                errors;

   initial begin
      errors = 0;
   end

   function automatic parsed_edge_type make_result(input status_type s, input logic [63:0] a,
                                                   input logic [63:0] d);
      parsed_edge_type r;
      r.status     = s;
      r.source_key = a[KEY_OUT_W-1:0];
      r.dest_key   = d[KEY_OUT_W-1:0];
      return r;
   endfunction

   task automatic drop_key();
      key_value  = '0;
      key_digits = 0;
      in_key     = 1'b0;
   endtask

   task automatic complete_key(inout bit got, inout parsed_edge_type res);
      logic [63:0] key;
      key = key_value;
      drop_key();
      if (!have_src) begin
         src_value = key;
         have_src  = 1'b1;
      end else begin
         have_src = 1'b0;
         if (src_value != key) begin
            got = 1'b1;
            res = make_result(ST_EDGE, src_value, key);
         end
         src_value = '0;
      end
   endtask

   task automatic parse_text_byte(input logic [7:0] b, input logic last);
      bit              got;
      parsed_edge_type res;
      got = 1'b0;
      res = '0;
      if (b == delim_a || b == delim_b) begin
         skipping = 1'b0;
         if (in_key) complete_key(got, res);
      end else if (b >= CHAR_ZERO && b <= CHAR_ZERO + BYTE_W'(DIGIT_MAX)) begin
         if (!skipping) begin
            if (key_digits >= KEY_DIGIT_LIMIT) begin
               drop_key();
               have_src  = 1'b0;
               src_value = '0;
               skipping  = 1'b1;
               got       = 1'b1;
               res       = make_result(ST_TOO_LONG, '0, '0);
            end else begin
               key_value  = key_value * 10 + 64'(b - CHAR_ZERO);
               key_digits = key_digits + 1;
               in_key     = 1'b1;
            end
         end
      end else begin
         drop_key();
         skipping = 1'b0;
         got      = 1'b1;
         res      = make_result(ST_MALFORMED, '0, '0);
      end
      if (last) begin
         skipping = 1'b0;
         if (in_key && !got) complete_key(got, res);
         else if (in_key) drop_key();
         if (have_src) begin
            have_src  = 1'b0;
            src_value = '0;
            if (!got) begin
               got = 1'b1;
               res = make_result(ST_MALFORMED, '0, '0);
            end
         end
      end
      if (got) expected_edges = {expected_edges, res};
   endtask

   task automatic check_result();
      parsed_edge_type want;
      parsed_edge_type seen;
      seen.status     = status_type'(rsp_tuser);
      seen.source_key = rsp_tdata[KEY_OUT_W-1:0];
      seen.dest_key   = rsp_tdata[2*KEY_OUT_W-1:KEY_OUT_W];
      if (expected_edges.size() == 0) begin
         errors++;
         $display("%0t: unexpected result, expected none, got status %0d source %0d dest %0d",
                  $time, seen.status, seen.source_key, seen.dest_key);
         return;
      end
      want = expected_edges.pop_front();
      if (seen.status !== want.status) begin
         errors++;
         $display("%0t: status mismatch, expected %0d, got %0d",
                  $time, want.status, seen.status);
      end
      if (seen.source_key !== want.source_key) begin
         errors++;
         $display("%0t: source key mismatch, expected %0d, got %0d",
                  $time, want.source_key, seen.source_key);
      end
      if (seen.dest_key !== want.dest_key) begin
         errors++;
         $display("%0t: dest key mismatch, expected %0d, got %0d",
                  $time, want.dest_key, seen.dest_key);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_edges.delete();
         delim_a   = DELIM_ONE_RESET;
         delim_b   = DELIM_TWO_RESET;
         drop_key();
         have_src  = 1'b0;
         src_value = '0;
         skipping  = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_DELIM_ONE) delim_a = csr_data;
            else if (csr_index == REG_DELIM_TWO) delim_b = csr_data;
         end
         if (req_tvalid && req_tready) parse_text_byte(req_tdata, req_tlast);
      end
      pending    <= expected_edges.size();
      fail_count <= errors;
   end

endmodule

/* test/tb_edge_list_text_parser_unit.sv */
`timescale 1ns / 100ps
// Testbench top for the edge list text parser: clock, reset, stimulus and the final verdict.
module tb_edge_list_text_parser_unit;
   import elp_pkg::*;

   localparam int STALL_LIMIT  = 1000;
   localparam int PHASE_ITEMS  = 325;
   localparam int PHASES       = 6;
   localparam int MAX_GAP      = 13;
   localparam int DRAIN_CYCLES = 8;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [79:0]            rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [7:0]             csr_data   = '0;
   int                     fail_count;
   int                     pending;

   int                     bytes_sent   = 0;
   int                     stall_cycles = 0;
   bit                     calm_tx      = 1'b0;
   bit                     calm_rx      = 1'b0;
   logic [7:0]             cur_d1;
   logic [7:0]             cur_d2;
   logic [7:0]             saved_digits[16];
   int                     saved_len    = 1;

   edge_list_text_parser_unit dut (.*);

   elp_result_checker u_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = calm_rx ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   task automatic send_byte(input logic [7:0] b, input bit last);
      int gap;
      gap = calm_tx ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= b;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      bytes_sent++;
   endtask

   task automatic send_text(input string s, input bit last);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], last && i == s.len() - 1);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_delimiters(input logic [7:0] d1, input logic [7:0] d2);
      csr_index <= REG_DELIM_ONE;
      csr_data  <= d1;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_index <= REG_DELIM_TWO;
      csr_data  <= d2;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      cur_d1 = d1;
      cur_d2 = d2;
   endtask

   function automatic logic [7:0] random_digit();
      if ($urandom_range(0, 3) == 0) return CHAR_ZERO + BYTE_W'(DIGIT_MAX);
      return CHAR_ZERO + BYTE_W'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] random_delim();
      return $urandom_range(0, 1) ? cur_d1 : cur_d2;
   endfunction

   function automatic int key_length();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 14) return $urandom_range(1, 4);
      if (pick < 17) return MAX_KEY_DIGITS_DFLT;
      return $urandom_range(MAX_KEY_DIGITS_DFLT + 1, MAX_KEY_DIGITS_DFLT + 3);
   endfunction

   // A repeated key reuses the digits of the previous one, which makes a self-loop.
   task automatic send_key(input int len, input bit copy_prev, input bit end_chunk);
      int n;
      n = copy_prev ? saved_len : len;
      for (int i = 0; i < n; i++) begin
         if (!copy_prev) saved_digits[i] = random_digit();
         send_byte(saved_digits[i], end_chunk && i == n - 1);
      end
      if (!copy_prev) saved_len = n;
   endtask

   task automatic send_group();
      int pick;
      int ending;
      if ($urandom_range(0, 29) == 0) calm_tx = !calm_tx;
      if ($urandom_range(0, 29) == 0) calm_rx = !calm_rx;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         send_key(key_length(), 1'b0, 1'b0);
         send_byte(random_delim(), 1'b0);
         ending = $urandom_range(0, 3);
         send_key(key_length(), $urandom_range(0, 2) == 0, ending == 0);
         if (ending != 0) send_byte(random_delim(), ending == 1);
      end else if (pick < 80) begin
         send_key(key_length(), 1'b0, $urandom_range(0, 1) == 1);
         if ($urandom_range(0, 1) == 1) send_byte(random_delim(), $urandom_range(0, 1) == 1);
      end else if (pick < 92) begin
         send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else begin
         send_byte(random_delim(), $urandom_range(0, 2) == 0);
      end
   endtask

   initial begin
      logic [7:0] phase_d1[PHASES];
      logic [7:0] phase_d2[PHASES];
      int         target;
      phase_d1 = '{DELIM_ONE_RESET, 8'h00, 8'h35, 8'hFF, CHAR_ZERO, 8'h00};
      phase_d2 = '{DELIM_TWO_RESET, 8'hFF, 8'h2C, 8'h00, CHAR_ZERO + 8'h09, 8'h00};
      phase_d1[PHASES-1] = 8'($urandom_range(0, 255));
      phase_d2[PHASES-1] = 8'($urandom_range(0, 255));
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < PHASES; p++) begin
         settle();
         write_delimiters(phase_d1[p], phase_d2[p]);
         if (p == 0) begin
            send_text("0 999999999999", 1'b1);
            send_text("5\n5 x", 1'b0);
            send_byte(8'h00, 1'b0);
            send_byte(8'hFF, 1'b0);
            send_text("4", 1'b1);
         end
         target = bytes_sent + PHASE_ITEMS;
         while (bytes_sent < target) send_group();
      end
      settle();
      if (fail_count == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
